>>> hdl/occupancy_grid_window_gate_assert.svh
// assertion macros for the occupancy grid window gate
`ifndef OCCUPANCY_GRID_WINDOW_GATE_ASSERT_SVH
`define OCCUPANCY_GRID_WINDOW_GATE_ASSERT_SVH

// same-cycle implication, checked out of reset only
`define OGWG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset only
`define OGWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ogwg_pkg.sv
package ogwg_pkg;

	localparam int ACTION_W = 2;
	localparam int BIN_W    = 5;
	localparam int LIMIT_W  = 16;
	localparam int SUM_W    = 24;
	localparam int TOTAL_W  = 32;
	localparam int GRID_W   = 6;
	localparam int RADIUS_W = 3;
	localparam int CFG_IDX_W = 2;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam action_t ACT_ADD       = 2'd0;
	localparam action_t ACT_ADD_EMPTY = 2'd1;
	localparam action_t ACT_ADD_LIMIT = 2'd2;
	localparam action_t ACT_QUERY     = 2'd3;

	localparam cfg_idx_t REG_COLUMNS = 2'd0;
	localparam cfg_idx_t REG_ROWS    = 2'd1;
	localparam cfg_idx_t REG_RADIUS  = 2'd2;

	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [GRID_W-1:0]   COLUMNS_RESET = 6'd32;
	localparam logic [GRID_W-1:0]   ROWS_RESET    = 6'd32;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 3'd1;

endpackage

>>> hdl/occupancy_grid_window_gate.sv
// occupancy grid with a square neighborhood gate
//
// input channel (in_valid / in_stall) carries one request: action, column, row and
// point_limit. output channel (out_valid / out_stall) returns one result per request:
// accepted, window_sum, point_total and bad_bin. the config port (cfg_write, cfg_index,
// cfg_data) sets columns_in_use, rows_in_use and window_radius.
//
// after reset the bin store is cleared one bin a cycle, all MAX_COLUMNS*MAX_ROWS bins
// (1024 at the defaults); in_stall stays high until that sweep ends. config writes are
// taken during the sweep; the user writes columns_in_use, rows_in_use and window_radius
// only while the block is idle, and the block itself does not enforce it. one request
// occupies the block from accept to result: a bad bin passes setup and done, a plain
// add setup, write and done, a windowed action setup, scan, drain, decide, write (when
// it adds the point) and done. the W bins of the clipped window (up to 9 at radius 1,
// 49 at radius 3, 225 at radius 7) are read one bin a cycle via the single read port.
// a finished result sits in the output register until taken; the next request may be
// accepted meanwhile, but its result waits while out_stall holds the previous one.
module occupancy_grid_window_gate
	import ogwg_pkg::*;
#(
	parameter int MAX_COLUMNS = 32,
	parameter int MAX_ROWS    = 32,
	parameter int MAX_RADIUS  = 7,
	parameter int COUNT_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GRID_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ACTION_W-1:0]  action,
	input  logic [BIN_W-1:0]     column,
	input  logic [BIN_W-1:0]     row,
	input  logic [LIMIT_W-1:0]   point_limit,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 accepted,
	output logic [SUM_W-1:0]     window_sum,
	output logic [TOTAL_W-1:0]   point_total,
	output logic                 bad_bin
);

	localparam int GRID_CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int AW = GRID_CELLS > 1 ? $clog2(GRID_CELLS) : 1;
	localparam int ACC_W = (COUNT_BITS > SUM_W ? COUNT_BITS : SUM_W) + 1;
	localparam logic [AW-1:0] LAST_CELL = AW'(GRID_CELLS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SETUP  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_DECIDE = 3'd5;
	localparam logic [2:0] S_WR     = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]          state_q;
	logic [GRID_W-1:0]   cols_q;
	logic [GRID_W-1:0]   rows_q;
	logic [RADIUS_W-1:0] radius_q;

	logic [ACTION_W-1:0] act_q;
	logic [BIN_W-1:0]    col_q;
	logic [BIN_W-1:0]    row_q;
	logic [LIMIT_W-1:0]  limit_q;

	logic [BIN_W-1:0]    x_q;
	logic [BIN_W-1:0]    y_q;
	logic [BIN_W-1:0]    x0_q;
	logic [GRID_W-1:0]   x1_q;
	logic [GRID_W-1:0]   y1_q;
	logic                rd_pend_q;
	logic [SUM_W-1:0]    acc_q;
	logic                res_acc_q;
	logic                bad_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [AW-1:0]       clr_q;

	logic                out_valid_q;
	logic                accepted_q;
	logic [SUM_W-1:0]    window_sum_q;
	logic [TOTAL_W-1:0]  point_total_q;
	logic                bad_bin_q;

	logic [GRID_W-1:0]   ncols;
	logic [GRID_W-1:0]   nrows;
	logic [RADIUS_W-1:0] rad;
	logic [BIN_W-1:0]    x0;
	logic [BIN_W-1:0]    y0;
	logic [GRID_W:0]     x_end;
	logic [GRID_W:0]     y_end;
	logic [GRID_W-1:0]   x1;
	logic [GRID_W-1:0]   y1;
	logic                bad;
	logic                x_last;
	logic                y_last;
	logic                add_pt;
	logic                out_free;
	logic [31:0]         scan_lin;
	logic [31:0]         ctr_lin;
	logic [ACC_W-1:0]    acc_sum;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;

	// grid size and radius above the build limits act as the limits
	assign ncols = (32'(cols_q) > 32'(MAX_COLUMNS)) ? GRID_W'(MAX_COLUMNS) : cols_q;
	assign nrows = (32'(rows_q) > 32'(MAX_ROWS)) ? GRID_W'(MAX_ROWS) : rows_q;
	assign rad = (32'(radius_q) > 32'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_q;

	// clipped window bounds, upper ones exclusive
	assign x0 = (col_q > BIN_W'(rad)) ? col_q - BIN_W'(rad) : '0;
	assign y0 = (row_q > BIN_W'(rad)) ? row_q - BIN_W'(rad) : '0;
	assign x_end = (GRID_W+1)'(col_q) + (GRID_W+1)'(rad) + 1'b1;
	assign y_end = (GRID_W+1)'(row_q) + (GRID_W+1)'(rad) + 1'b1;
	assign x1 = (x_end > (GRID_W+1)'(ncols)) ? ncols : x_end[GRID_W-1:0];
	assign y1 = (y_end > (GRID_W+1)'(nrows)) ? nrows : y_end[GRID_W-1:0];
	assign bad = (GRID_W'(col_q) >= ncols) || (GRID_W'(row_q) >= nrows);

	assign x_last = (GRID_W'(x_q) + 1'b1) == x1_q;
	assign y_last = (GRID_W'(y_q) + 1'b1) == y1_q;

	assign scan_lin = 32'(y_q) * 32'(MAX_COLUMNS) + 32'(x_q);
	assign ctr_lin  = 32'(row_q) * 32'(MAX_COLUMNS) + 32'(col_q);

	assign acc_sum = ACC_W'(acc_q) + ACC_W'(ram_rdata);

	assign add_pt = ((act_q == ACT_ADD_EMPTY) && (acc_q == '0)) ||
		((act_q == ACT_ADD_LIMIT) && (acc_q < SUM_W'(limit_q)));

	assign out_free = !out_valid_q || !out_stall;

	// bin store ports: sweep writes zero, increment writes center count plus one, saturating at the count maximum
	assign ram_we = (state_q == S_CLEAR) || (state_q == S_WR);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : AW'(ctr_lin);
	assign ram_wdata = (state_q == S_CLEAR) ? '0 :
		((ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1);
	assign ram_raddr = (state_q == S_SCAN) ? AW'(scan_lin) : AW'(ctr_lin);

	ogwg_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(GRID_CELLS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= COLUMNS_RESET;
			rows_q   <= ROWS_RESET;
			radius_q <= RADIUS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_COLUMNS: cols_q <= cfg_data;
				REG_ROWS:    rows_q <= cfg_data;
				REG_RADIUS:  radius_q <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rd_pend_q   <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == S_SCAN);
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (bad) begin
						state_q <= S_DONE;
					end else if (act_q == ACT_ADD) begin
						state_q <= S_WR;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (x_last && y_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= add_pt ? S_WR : S_DONE;
				end
				S_WR: begin
					if (total_q != TOTAL_MAX) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			act_q     <= action;
			col_q     <= column;
			row_q     <= row;
			limit_q   <= point_limit;
			acc_q     <= '0;
			res_acc_q <= 1'b0;
			bad_q     <= 1'b0;
		end
		if (state_q == S_SETUP) begin
			x_q  <= x0;
			y_q  <= y0;
			x0_q <= x0;
			x1_q <= x1;
			y1_q <= y1;
			bad_q <= bad;
			res_acc_q <= !bad && (act_q == ACT_ADD);
		end
		if (state_q == S_SCAN) begin
			if (x_last) begin
				x_q <= x0_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
		if (rd_pend_q) begin
			// window sum saturates at the field maximum
			acc_q <= (acc_sum > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];
		end
		if (state_q == S_DECIDE) begin
			res_acc_q <= add_pt || ((act_q == ACT_QUERY) && (acc_q == '0));
		end
		if (state_q == S_DONE && out_free) begin
			accepted_q    <= res_acc_q;
			window_sum_q  <= acc_q;
			point_total_q <= total_q;
			bad_bin_q     <= bad_q;
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign window_sum  = window_sum_q;
	assign point_total = point_total_q;
	assign bad_bin     = bad_bin_q;

`include "occupancy_grid_window_gate_assert.svh"

	`OGWG_ASSERT_NOW(a_write_state, ram_we, (state_q == S_CLEAR) || (state_q == S_WR), "bin store written outside sweep or increment")
	`OGWG_ASSERT_NEXT(a_total_hold, state_q != S_WR, $stable(total_q), "point total moved without an added point")
	`OGWG_ASSERT_NOW(a_no_result_in_sweep, state_q == S_CLEAR, !out_valid_q, "result presented during clearing sweep")
	`OGWG_ASSERT_NEXT(a_bad_no_add, (state_q == S_SETUP) && bad, state_q == S_DONE, "bad bin went on to scan or write")

endmodule

>>> hdl/ogwg_ram.sv
module ogwg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
